/* hdl/ofb_pkg.sv */
// Shared types, command codes and helpers for the orthonormal frame builder.
// Depends on nothing; every other file imports it.
package ofb_pkg;

    // Default fraction bits of the signed fixed-point format
    localparam int FRAC_BITS_DEF = 14;

    // Magnitudes are brought below 2^NORM_BITS before squaring
    localparam int NORM_BITS = 30;

    // Command codes
    localparam logic [1:0] CMD_NORMAL   = 2'd0;
    localparam logic [1:0] CMD_TANGENT  = 2'd1;
    localparam logic [1:0] CMD_HINT     = 2'd2;
    localparam logic [1:0] CMD_HINT_ALT = 2'd3;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic signed [15:0] bitangent_x;
        logic signed [15:0] bitangent_y;
        logic signed [15:0] bitangent_z;
        logic        [1:0]  command;
        logic               flip_request;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] frame_s_x;
        logic signed [15:0] frame_s_y;
        logic signed [15:0] frame_s_z;
        logic signed [15:0] frame_t_x;
        logic signed [15:0] frame_t_y;
        logic signed [15:0] frame_t_z;
        logic signed [15:0] frame_n_x;
        logic signed [15:0] frame_n_y;
        logic signed [15:0] frame_n_z;
        logic               degenerate;
    } out_item_t;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Clamp to the 16-bit signed range
    function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
        logic signed [15:0] r;
        if (x > 64'sd32767)
        begin
            r = 16'sh7fff;
        end
        else if (x < -64'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = x[15:0];
        end
        return r;
    endfunction

endpackage

/* hdl/ofb_norm.sv */
// Pipelined vector normalizer: magnitude prescale, square sum, bit-per-stage
// square root, bit-per-stage rounded division. Depends on ofb_pkg.
module ofb_norm
#(
    parameter int VW     = 40,
    parameter int FRAC   = ofb_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W = 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic [3*VW-1:0]          in_vec,
    input  logic [SIDE_W-1:0]        in_side,
    output logic                     out_valid,
    output logic [3*(FRAC+2)-1:0]    out_vec,
    output logic                     out_zero,
    output logic [SIDE_W-1:0]        out_side
);
    import ofb_pkg::*;

    localparam int ML    = NORM_BITS;
    localparam int RB    = ML + 1;
    localparam int SUM_W = 2 * ML + 2;
    localparam int QW    = FRAC + 1;
    localparam int CW    = RB + FRAC + 1;
    localparam int OW    = FRAC + 2;
    localparam int KW    = (VW > 1) ? $clog2(VW) : 1;
    localparam int CY_W  = 3 + 3 * ML + SIDE_W;
    localparam int DC_W  = 3 + SIDE_W;
    localparam int LAT   = 4 + RB + QW + 1;

    logic [LAT-1:0]     vld_reg;

    logic [VW-1:0]      mag1_reg  [3];
    logic [VW-1:0]      mag1_next [3];
    logic [2:0]         neg1_reg;
    logic [SIDE_W-1:0]  side1_reg;

    logic [VW-1:0]      orv;
    logic [KW-1:0]      shamt;
    logic [3*ML-1:0]    m2_next;
    logic [3*ML-1:0]    m2_reg;
    logic [2:0]         neg2_reg;
    logic [SIDE_W-1:0]  side2_reg;

    logic [2*ML-1:0]    sq3_reg [3];
    logic [CY_W-1:0]    cy3_reg;
    logic [SUM_W-1:0]   sum4_reg;
    logic [CY_W-1:0]    cy4_reg;

    logic [SUM_W-1:0]   sx_reg  [RB];
    logic [SUM_W-1:0]   sx_next [RB];
    logic [SUM_W-1:0]   sr_reg  [RB];
    logic [SUM_W-1:0]   sr_next [RB];
    logic [CY_W-1:0]    scy_reg [RB];

    logic [CW-1:0]      rem_reg  [QW][3];
    logic [CW-1:0]      rem_next [QW][3];
    logic [QW-1:0]      quo_reg  [QW][3];
    logic [QW-1:0]      quo_next [QW][3];
    logic [RB-1:0]      dl_reg   [QW];
    logic [RB-1:0]      dl_next  [QW];
    logic [DC_W-1:0]    dcy_reg  [QW];
    logic [DC_W-1:0]    dcy_next [QW];

    logic [3*OW-1:0]    o_next;
    logic [3*OW-1:0]    o_reg;
    logic               zero_reg;
    logic [SIDE_W-1:0]  oside_reg;

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // Take magnitudes and signs
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag1_next[i] = in_vec[i*VW+VW-1] ? (~in_vec[i*VW +: VW] + 1'b1)
                                             : in_vec[i*VW +: VW];
        end
    end

    // Find the common prescale from the highest set bit of all magnitudes
    always_comb
    begin
        orv   = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
        shamt = '0;
        for (int j = ML; j < VW; j++)
        begin
            if (orv[j])
            begin
                shamt = KW'(j - ML + 1);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            m2_next[i*ML +: ML] = ML'(mag1_reg[i] >> shamt);
        end
    end

    // Square root, one result bit per stage
    always_comb
    begin
        logic [SUM_W-1:0] xi;
        logic [SUM_W-1:0] ri;
        logic [SUM_W-1:0] bt;
        logic [SUM_W-1:0] tr;
        for (int q = 0; q < RB; q++)
        begin
            xi = (q == 0) ? sum4_reg : sx_reg[(q == 0) ? 0 : q - 1];
            ri = (q == 0) ? '0 : sr_reg[(q == 0) ? 0 : q - 1];
            bt = SUM_W'(1) << (2 * (RB - 1 - q));
            tr = ri + bt;
            if (xi >= tr)
            begin
                sx_next[q] = xi - tr;
                sr_next[q] = (ri >> 1) + bt;
            end
            else
            begin
                sx_next[q] = xi;
                sr_next[q] = ri >> 1;
            end
        end
    end

    // Rounded division by the length, one quotient bit per stage
    always_comb
    begin
        logic [CW-1:0] ri;
        logic [CW-1:0] dv;
        logic [QW-1:0] qi;
        logic [RB-1:0] li;
        logic [CY_W-1:0] cy;
        cy = scy_reg[RB-1];
        for (int j = 0; j < QW; j++)
        begin
            if (j == 0)
            begin
                li          = sr_reg[RB-1][RB-1:0];
                dcy_next[j] = {cy[CY_W-1 -: SIDE_W], cy[2:0]};
            end
            else
            begin
                li          = dl_reg[(j == 0) ? 0 : j - 1];
                dcy_next[j] = dcy_reg[(j == 0) ? 0 : j - 1];
            end
            dl_next[j] = li;
            dv = CW'(li) << (FRAC - j);
            for (int i = 0; i < 3; i++)
            begin
                if (j == 0)
                begin
                    ri = (CW'(cy[3+i*ML +: ML]) << FRAC) + CW'(li >> 1);
                    qi = '0;
                end
                else
                begin
                    ri = rem_reg[(j == 0) ? 0 : j - 1][i];
                    qi = quo_reg[(j == 0) ? 0 : j - 1][i];
                end
                if (ri >= dv)
                begin
                    rem_next[j][i] = ri - dv;
                    quo_next[j][i] = qi | (QW'(1) << (FRAC - j));
                end
                else
                begin
                    rem_next[j][i] = ri;
                    quo_next[j][i] = qi;
                end
            end
        end
    end

    // Restore signs, zero the axis on zero length
    always_comb
    begin
        logic [OW-1:0] qv;
        for (int i = 0; i < 3; i++)
        begin
            qv = OW'(quo_reg[QW-1][i]);
            if (dl_reg[QW-1] == '0)
            begin
                o_next[i*OW +: OW] = '0;
            end
            else if (dcy_reg[QW-1][i])
            begin
                o_next[i*OW +: OW] = ~qv + 1'b1;
            end
            else
            begin
                o_next[i*OW +: OW] = qv;
            end
        end
    end

    // Datapath registers, all held on stall
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag1_reg[i] <= mag1_next[i];
                neg1_reg[i] <= in_vec[i*VW+VW-1];
                sq3_reg[i]  <= (2*ML)'(m2_reg[i*ML +: ML]) * (2*ML)'(m2_reg[i*ML +: ML]);
            end
            side1_reg <= in_side;
            m2_reg    <= m2_next;
            neg2_reg  <= neg1_reg;
            side2_reg <= side1_reg;
            cy3_reg   <= {side2_reg, m2_reg, neg2_reg};
            sum4_reg  <= SUM_W'(sq3_reg[0]) + SUM_W'(sq3_reg[1]) + SUM_W'(sq3_reg[2]);
            cy4_reg   <= cy3_reg;
            for (int q = 0; q < RB; q++)
            begin
                sx_reg[q]  <= sx_next[q];
                sr_reg[q]  <= sr_next[q];
                scy_reg[q] <= (q == 0) ? cy4_reg : scy_reg[(q == 0) ? 0 : q - 1];
            end
            for (int j = 0; j < QW; j++)
            begin
                dl_reg[j]  <= dl_next[j];
                dcy_reg[j] <= dcy_next[j];
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[j][i] <= rem_next[j][i];
                    quo_reg[j][i] <= quo_next[j][i];
                end
            end
            o_reg     <= o_next;
            zero_reg  <= (dl_reg[QW-1] == '0);
            oside_reg <= dcy_reg[QW-1][DC_W-1 -: SIDE_W];
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign out_vec   = o_reg;
    assign out_zero  = zero_reg;
    assign out_side  = oside_reg;

endmodule

/* hdl/orthonormal_frame_builder_core.sv */
// Throughput: one transaction per cycle; the whole pipeline advances together and
// holds on output stall, and the input stage still fills when it is empty.
// The two normalizers set the depth: 31 square-root stages and FRAC_BITS+1 divide
// stages each. Reset clears only the valid bits; no clearing pass is needed.
module orthonormal_frame_builder_core
#(
    parameter int FRAC_BITS = ofb_pkg::FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              point_valid,
    output logic              point_ready,
    input  ofb_pkg::in_item_t point,
    output logic              frame_valid,
    input  logic              frame_ready,
    output ofb_pkg::out_item_t frame
);
    import ofb_pkg::*;

    localparam int F       = FRAC_BITS;
    localparam int IW      = $bits(in_item_t);
    localparam int EW      = imax(F, 15) + 2;
    localparam int C0W     = imax(imax(EW + F, EW + 16), 31) + 2;
    localparam int DOTW    = 34;
    localparam int DW      = DOTW - F;
    localparam int NDW     = 16 + DW;
    localparam int SV1W    = imax(16 + DW, 16 + F) + 1;
    localparam int SVW     = imax(C0W, SV1W);
    localparam int OW      = F + 2;
    localparam int XPW     = 16 + OW;
    localparam int X1W     = XPW + 1;
    localparam int TVW     = imax(C0W, X1W);
    localparam int HDW     = XPW + 2;
    localparam int TW      = OW + 1;
    localparam int SIDE1_W = 3 * C0W + IW;
    localparam int SIDE2_W = 3 * OW + 1 + IW;

    logic adv;

    // Stage 0: input register
    in_item_t it0_reg;
    logic     v0_reg;

    // Stage 1: products
    in_item_t                 it1_reg;
    logic                     v1_reg;
    logic signed [EW-1:0]     e1_next;
    logic signed [EW-1:0]     e1_reg;
    logic signed [EW-1:0]     absz;
    logic                     sg1_reg;
    logic signed [31:0]       pxx_reg;
    logic signed [31:0]       pxy_reg;
    logic signed [31:0]       pyy_reg;
    logic signed [16+EW-1:0]  pxe_reg;
    logic signed [16+EW-1:0]  pye_reg;
    logic signed [31:0]       dp_reg [3];

    // Stage 2: basis terms and rounded dot
    in_item_t                 it2_reg;
    logic                     v2_reg;
    logic signed [C0W-1:0]    ef;
    logic signed [C0W-1:0]    sv0_next [3];
    logic signed [C0W-1:0]    tv0_next [3];
    logic signed [C0W-1:0]    sv0_2_reg [3];
    logic signed [C0W-1:0]    tv0_2_reg [3];
    logic signed [DOTW-1:0]   dotr;
    logic signed [DW-1:0]     d2_reg;

    // Stage 3: normal times projection
    in_item_t                 it3_reg;
    logic                     v3_reg;
    logic signed [C0W-1:0]    sv0_3_reg [3];
    logic signed [C0W-1:0]    tv0_3_reg [3];
    logic signed [NDW-1:0]    nd3_reg [3];

    // Stage 4: tangent axis select
    in_item_t                 it4_reg;
    logic                     v4_reg;
    logic signed [SVW-1:0]    sv4_next [3];
    logic [3*SVW-1:0]         sv4_reg;
    logic [3*C0W-1:0]         tv0_4_reg;

    // First normalizer
    logic                     n1_valid;
    logic [3*OW-1:0]          n1_vec;
    logic                     n1_zero;
    logic [SIDE1_W-1:0]       n1_side;
    in_item_t                 it_n1;

    // Stage 5: cross products
    in_item_t                 it5_reg;
    logic                     v5_reg;
    logic [3*OW-1:0]          s5_reg;
    logic                     z1_5_reg;
    logic [3*C0W-1:0]         tv0_5_reg;
    logic signed [XPW-1:0]    cx5_reg [6];
    logic signed [OW-1:0]     sn [3];

    // Stage 6: bitangent axis select
    logic                     v6_reg;
    logic signed [TVW-1:0]    tv6_next [3];
    logic [3*TVW-1:0]         tv6_reg;
    logic [SIDE2_W-1:0]       side6_reg;

    // Second normalizer
    logic                     n2_valid;
    logic [3*OW-1:0]          n2_vec;
    logic                     n2_zero;
    logic [SIDE2_W-1:0]       n2_side;
    in_item_t                 it_n2;

    // Stage 7: hint products
    in_item_t                 it7_reg;
    logic                     v7_reg;
    logic [3*OW-1:0]          s7_reg;
    logic [3*OW-1:0]          t7_reg;
    logic                     z1_7_reg;
    logic                     z2_7_reg;
    logic signed [XPW-1:0]    th7_reg [3];

    // Output stage
    logic                     frame_valid_reg;
    out_item_t                frame_next;
    out_item_t                frame_reg;

    // Advance the pipeline unless the result waits; an empty input stage still fills
    assign adv         = ~frame_valid_reg | frame_ready;
    assign point_ready = adv | ~v0_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg          <= 1'b0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
            v5_reg          <= 1'b0;
            v6_reg          <= 1'b0;
            v7_reg          <= 1'b0;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            if (point_ready)
            begin
                v0_reg <= point_valid;
            end
            if (adv)
            begin
                v1_reg          <= v0_reg;
                v2_reg          <= v1_reg;
                v3_reg          <= v2_reg;
                v4_reg          <= v3_reg;
                v5_reg          <= n1_valid;
                v6_reg          <= v5_reg;
                v7_reg          <= n2_valid;
                frame_valid_reg <= v7_reg;
            end
        end
    end

    // Hold the incoming transaction
    always_ff @(posedge clk)
    begin
        if (point_ready)
        begin
            it0_reg <= point;
        end
    end

    // Form 1 + |n_z|
    always_comb
    begin
        absz    = it0_reg.normal_z[15] ? -EW'(it0_reg.normal_z) : EW'(it0_reg.normal_z);
        e1_next = (EW'(1) <<< F) + absz;
    end

    // Form basis terms for the normal-only mode and the rounded dot for the others
    always_comb
    begin
        ef          = C0W'(e1_reg) <<< F;
        sv0_next[0] = ef - C0W'(pxx_reg);
        sv0_next[1] = -C0W'(pxy_reg);
        sv0_next[2] = sg1_reg ? -C0W'(pxe_reg) : C0W'(pxe_reg);
        tv0_next[0] = sg1_reg ? -C0W'(pxy_reg) : C0W'(pxy_reg);
        tv0_next[1] = sg1_reg ? (ef - C0W'(pyy_reg)) : (C0W'(pyy_reg) - ef);
        tv0_next[2] = -C0W'(pye_reg);
        dotr        = DOTW'(dp_reg[0]) + DOTW'(dp_reg[1]) + DOTW'(dp_reg[2])
                    + (DOTW'(1) <<< (F - 1));
    end

    // Remove the normal component and pick the tangent axis
    always_comb
    begin
        logic signed [SV1W-1:0] sv1;
        logic signed [15:0]     sc;
        for (int i = 0; i < 3; i++)
        begin
            case (i)
                0:       sc = it3_reg.tangent_x;
                1:       sc = it3_reg.tangent_y;
                default: sc = it3_reg.tangent_z;
            endcase
            sv1 = (SV1W'(sc) <<< F) - SV1W'(nd3_reg[i]);
            if (it3_reg.command == CMD_NORMAL)
            begin
                sv4_next[i] = SVW'(sv0_3_reg[i]);
            end
            else
            begin
                sv4_next[i] = SVW'(sv1);
            end
        end
    end

    // Front datapath registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it1_reg   <= it0_reg;
            e1_reg    <= e1_next;
            sg1_reg   <= ~it0_reg.normal_z[15];
            pxx_reg   <= it0_reg.normal_x * it0_reg.normal_x;
            pxy_reg   <= it0_reg.normal_x * it0_reg.normal_y;
            pyy_reg   <= it0_reg.normal_y * it0_reg.normal_y;
            pxe_reg   <= (16+EW)'(it0_reg.normal_x) * (16+EW)'(e1_next);
            pye_reg   <= (16+EW)'(it0_reg.normal_y) * (16+EW)'(e1_next);
            dp_reg[0] <= it0_reg.normal_x * it0_reg.tangent_x;
            dp_reg[1] <= it0_reg.normal_y * it0_reg.tangent_y;
            dp_reg[2] <= it0_reg.normal_z * it0_reg.tangent_z;

            it2_reg <= it1_reg;
            d2_reg  <= DW'(dotr >>> F);
            it3_reg <= it2_reg;
            it4_reg <= it3_reg;
            nd3_reg[0] <= NDW'(it2_reg.normal_x) * NDW'(d2_reg);
            nd3_reg[1] <= NDW'(it2_reg.normal_y) * NDW'(d2_reg);
            nd3_reg[2] <= NDW'(it2_reg.normal_z) * NDW'(d2_reg);
            for (int i = 0; i < 3; i++)
            begin
                sv0_2_reg[i] <= sv0_next[i];
                tv0_2_reg[i] <= tv0_next[i];
                sv0_3_reg[i] <= sv0_2_reg[i];
                tv0_3_reg[i] <= tv0_2_reg[i];
                sv4_reg[i*SVW +: SVW]   <= sv4_next[i];
                tv0_4_reg[i*C0W +: C0W] <= tv0_3_reg[i];
            end
        end
    end

    ofb_norm
    #(
        .VW     (SVW),
        .FRAC   (F),
        .SIDE_W (SIDE1_W)
    )
    u_norm_s
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v4_reg),
        .in_vec    (sv4_reg),
        .in_side   ({tv0_4_reg, it4_reg}),
        .out_valid (n1_valid),
        .out_vec   (n1_vec),
        .out_zero  (n1_zero),
        .out_side  (n1_side)
    );

    assign it_n1 = n1_side[IW-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sn[i] = n1_vec[i*OW +: OW];
        end
    end

    // Cross n with the normalized tangent
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it5_reg    <= it_n1;
            s5_reg     <= n1_vec;
            z1_5_reg   <= n1_zero;
            tv0_5_reg  <= n1_side[SIDE1_W-1 -: 3*C0W];
            cx5_reg[0] <= XPW'(it_n1.normal_y) * XPW'(sn[2]);
            cx5_reg[1] <= XPW'(it_n1.normal_z) * XPW'(sn[1]);
            cx5_reg[2] <= XPW'(it_n1.normal_z) * XPW'(sn[0]);
            cx5_reg[3] <= XPW'(it_n1.normal_x) * XPW'(sn[2]);
            cx5_reg[4] <= XPW'(it_n1.normal_x) * XPW'(sn[1]);
            cx5_reg[5] <= XPW'(it_n1.normal_y) * XPW'(sn[0]);
        end
    end

    // Pick the bitangent axis
    always_comb
    begin
        logic signed [X1W-1:0] tv1;
        logic signed [C0W-1:0] tc;
        for (int i = 0; i < 3; i++)
        begin
            tv1 = X1W'(cx5_reg[2*i]) - X1W'(cx5_reg[2*i+1]);
            tc  = tv0_5_reg[i*C0W +: C0W];
            if (it5_reg.command == CMD_NORMAL)
            begin
                tv6_next[i] = TVW'(tc);
            end
            else
            begin
                tv6_next[i] = TVW'(tv1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tv6_reg[i*TVW +: TVW] <= tv6_next[i];
            end
            side6_reg <= {s5_reg, z1_5_reg, it5_reg};
        end
    end

    ofb_norm
    #(
        .VW     (TVW),
        .FRAC   (F),
        .SIDE_W (SIDE2_W)
    )
    u_norm_t
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v6_reg),
        .in_vec    (tv6_reg),
        .in_side   (side6_reg),
        .out_valid (n2_valid),
        .out_vec   (n2_vec),
        .out_zero  (n2_zero),
        .out_side  (n2_side)
    );

    assign it_n2 = n2_side[IW-1:0];

    // Project the bitangent on the hint
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it7_reg    <= it_n2;
            s7_reg     <= n2_side[SIDE2_W-1 -: 3*OW];
            z1_7_reg   <= n2_side[IW];
            z2_7_reg   <= n2_zero;
            t7_reg     <= n2_vec;
            th7_reg[0] <= XPW'($signed(n2_vec[0*OW +: OW])) * XPW'(it_n2.bitangent_x);
            th7_reg[1] <= XPW'($signed(n2_vec[1*OW +: OW])) * XPW'(it_n2.bitangent_y);
            th7_reg[2] <= XPW'($signed(n2_vec[2*OW +: OW])) * XPW'(it_n2.bitangent_z);
        end
    end

    // Orient, zero on degenerate, flip and saturate
    always_comb
    begin
        logic signed [HDW-1:0] dt;
        logic                  hint;
        logic                  ok;
        logic                  tneg;
        logic signed [TW-1:0]  sf [3];
        logic signed [TW-1:0]  tf [3];
        logic signed [16:0]    nf [3];
        dt   = HDW'(th7_reg[0]) + HDW'(th7_reg[1]) + HDW'(th7_reg[2]);
        hint = (it7_reg.command == CMD_HINT) || (it7_reg.command == CMD_HINT_ALT);
        ok   = ~z1_7_reg & ~z2_7_reg;
        tneg = hint & ~z2_7_reg & dt[HDW-1];
        nf[0] = 17'(it7_reg.normal_x);
        nf[1] = 17'(it7_reg.normal_y);
        nf[2] = 17'(it7_reg.normal_z);
        for (int i = 0; i < 3; i++)
        begin
            sf[i] = TW'($signed(s7_reg[i*OW +: OW]));
            tf[i] = TW'($signed(t7_reg[i*OW +: OW]));
            if (tneg)
            begin
                tf[i] = -tf[i];
            end
            if (!ok)
            begin
                sf[i] = '0;
                tf[i] = '0;
            end
            if (it7_reg.flip_request)
            begin
                tf[i] = -tf[i];
                nf[i] = -nf[i];
            end
        end
        frame_next.frame_s_x  = sat16(64'(sf[0]));
        frame_next.frame_s_y  = sat16(64'(sf[1]));
        frame_next.frame_s_z  = sat16(64'(sf[2]));
        frame_next.frame_t_x  = sat16(64'(tf[0]));
        frame_next.frame_t_y  = sat16(64'(tf[1]));
        frame_next.frame_t_z  = sat16(64'(tf[2]));
        frame_next.frame_n_x  = sat16(64'(nf[0]));
        frame_next.frame_n_y  = sat16(64'(nf[1]));
        frame_next.frame_n_z  = sat16(64'(nf[2]));
        frame_next.degenerate = ~ok;
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            frame_reg <= frame_next;
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

endmodule

/* test/ofb_checker.sv */
`timescale 1ns / 100ps
// Frame checker for the orthonormal frame builder: watches both channels,
// predicts each frame in fixed point and compares it with the whole output frame.
// Depends on ofb_pkg for the transaction types and command codes.
module ofb_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               point_valid,
    input  logic               point_ready,
    input  ofb_pkg::in_item_t  point,
    input  logic               frame_valid,
    input  logic               frame_ready,
    input  ofb_pkg::out_item_t frame,
    output int                 fail_count,
    output int                 pending_frames
);
    import ofb_pkg::*;

    localparam int FB = 14;
    localparam longint ONE = 64'sd1 << FB;

    out_item_t expected_frames[$];

    function automatic longint floor_shr(input longint x, input int k);
        return x >>> k;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Scale a vector to unit length; return 0 on zero length
    function automatic bit unit_vec(input longint v[3], output longint o[3]);
        longint unsigned mag[3];
        longint unsigned mx;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        int k;
        mx = 0;
        sum = 0;
        k = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > mx)
                mx = mag[i];
        end
        while (k < 63 && (mx >> k) >= (64'd1 << 30))
            k++;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = mag[i] >> k;
            sum += mag[i] * mag[i];
        end
        len = int_sqrt(sum);
        if (len == 0)
        begin
            for (int i = 0; i < 3; i++)
                o[i] = 0;
            return 0;
        end
        for (int i = 0; i < 3; i++)
        begin
            q = (mag[i] * longint'(ONE) + len / 2) / len;
            o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint x);
        if (x > 32767)
            return 16'sh7fff;
        if (x < -32768)
            return 16'sh8000;
        return x[15:0];
    endfunction

    function automatic out_item_t build_frame(input in_item_t p);
        longint n[3];
        longint s[3];
        longint h[3];
        longint sv[3];
        longint tv[3];
        longint ax_s[3];
        longint ax_t[3];
        longint sg;
        longint e;
        longint dp;
        longint d;
        longint dt;
        bit ok_s;
        bit ok_t;
        out_item_t r;
        n = '{p.normal_x, p.normal_y, p.normal_z};
        s = '{p.tangent_x, p.tangent_y, p.tangent_z};
        h = '{p.bitangent_x, p.bitangent_y, p.bitangent_z};
        if (p.command == CMD_NORMAL)
        begin
            sg = (n[2] >= 0) ? 1 : -1;
            e = ONE + ((n[2] < 0) ? -n[2] : n[2]);
            sv[0] = e * ONE - n[0] * n[0];
            sv[1] = -(n[0] * n[1]);
            sv[2] = -sg * n[0] * e;
            tv[0] = -sg * n[0] * n[1];
            tv[1] = sg * (e * ONE - n[1] * n[1]);
            tv[2] = -(n[1] * e);
            ok_s = unit_vec(sv, ax_s);
            ok_t = unit_vec(tv, ax_t);
        end
        else
        begin
            dp = n[0] * s[0] + n[1] * s[1] + n[2] * s[2];
            d = floor_shr(dp + (ONE >>> 1), FB);
            for (int i = 0; i < 3; i++)
                sv[i] = s[i] * ONE - n[i] * d;
            ok_s = unit_vec(sv, ax_s);
            tv[0] = n[1] * ax_s[2] - n[2] * ax_s[1];
            tv[1] = n[2] * ax_s[0] - n[0] * ax_s[2];
            tv[2] = n[0] * ax_s[1] - n[1] * ax_s[0];
            ok_t = unit_vec(tv, ax_t);
            // Hint commands orient T toward the bitangent hint
            if ((p.command == CMD_HINT || p.command == CMD_HINT_ALT) && ok_t)
            begin
                dt = ax_t[0] * h[0] + ax_t[1] * h[1] + ax_t[2] * h[2];
                if (dt < 0)
                    for (int i = 0; i < 3; i++)
                        ax_t[i] = -ax_t[i];
            end
        end
        if (!(ok_s && ok_t))
            for (int i = 0; i < 3; i++)
            begin
                ax_s[i] = 0;
                ax_t[i] = 0;
            end
        if (p.flip_request)
            for (int i = 0; i < 3; i++)
            begin
                ax_t[i] = -ax_t[i];
                n[i] = -n[i];
            end
        r.frame_s_x = clamp16(ax_s[0]);
        r.frame_s_y = clamp16(ax_s[1]);
        r.frame_s_z = clamp16(ax_s[2]);
        r.frame_t_x = clamp16(ax_t[0]);
        r.frame_t_y = clamp16(ax_t[1]);
        r.frame_t_z = clamp16(ax_t[2]);
        r.frame_n_x = clamp16(n[0]);
        r.frame_n_y = clamp16(n[1]);
        r.frame_n_z = clamp16(n[2]);
        r.degenerate = !(ok_s && ok_t);
        return r;
    endfunction

    assign pending_frames = expected_frames.size();

    // Predict on each input transaction, compare on each output transaction
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            expected_frames.delete();
        end
        else
        begin
            if (point_valid && point_ready)
                expected_frames.push_back(build_frame(point));
            if (frame_valid && frame_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    $display("%0t: unexpected frame %h", $time, frame);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (want !== frame)
                    begin
                        $display("%0t: frame mismatch expected %h actual %h",
                                 $time, want, frame);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// Testbench top for orthonormal_frame_builder_core: drives points with bursts
// and gaps, stalls the frame side, and reports the verdict from ofb_checker.
module tb;
    import ofb_pkg::*;

    localparam int LATENCY = 110;

    logic      clk;
    logic      rst_n;
    logic      point_valid;
    logic      point_ready;
    in_item_t  point;
    logic      frame_valid;
    logic      frame_ready;
    out_item_t frame;
    int        fail_count;
    int        pending_frames;
    bit        long_hold;

    orthonormal_frame_builder_core uut
    (
        .clk(clk), .rst_n(rst_n),
        .point_valid(point_valid), .point_ready(point_ready), .point(point),
        .frame_valid(frame_valid), .frame_ready(frame_ready), .frame(frame)
    );

    ofb_checker checker_i
    (
        .clk(clk), .rst_n(rst_n),
        .point_valid(point_valid), .point_ready(point_ready), .point(point),
        .frame_valid(frame_valid), .frame_ready(frame_ready), .frame(frame),
        .fail_count(fail_count), .pending_frames(pending_frames)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [15:0] pick_comp(input int sel);
        case (sel)
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sd16384;
            3: return -16'sd16384;
            4: return 16'sd0;
            default: return 16'($urandom);
        endcase
    endfunction

    // Random point, mostly with each normal component in -16384..16384, with random content
    function automatic in_item_t rand_point();
        in_item_t p;
        int a;
        p = $bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
        a = $urandom_range(0, 9);
        if (a < 6)
        begin
            p.normal_x = 16'($signed($urandom_range(0, 32768)) - 16384);
            p.normal_y = 16'($signed($urandom_range(0, 32768)) - 16384);
            p.normal_z = 16'($signed($urandom_range(0, 32768)) - 16384);
        end
        else if (a < 8)
        begin
            p.normal_x = pick_comp($urandom_range(0, 6));
            p.tangent_y = pick_comp($urandom_range(0, 6));
            p.bitangent_z = pick_comp($urandom_range(0, 6));
        end
        else if (a == 8)
        begin
            // tangent parallel to the normal
            p.tangent_x = p.normal_x;
            p.tangent_y = p.normal_y;
            p.tangent_z = p.normal_z;
        end
        p.command = 2'($urandom_range(0, 3));
        return p;
    endfunction

    // Offer one transaction and hold it until accepted
    task automatic send_point(input in_item_t p);
        point <= p;
        point_valid <= 1'b1;
        do
            @(posedge clk);
        while (!point_ready);
        @(negedge clk);
    endtask

    function automatic in_item_t make_point(input logic signed [15:0] nx, ny, nz,
                                            tx, ty, tz, hx, hy, hz,
                                            input logic [1:0] cmd,
                                            input logic fl);
        in_item_t p;
        p = '{nx, ny, nz, tx, ty, tz, hx, hy, hz, cmd, fl};
        return p;
    endfunction

    // Receiver stall pattern, with one long hold-off counted here
    initial
    begin
        int c;
        int held;
        frame_ready = 1'b0;
        c = 0;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            c++;
            if (long_hold && held < 400)
            begin
                held++;
                frame_ready <= 1'b0;
            end
            else if ((c / 64) % 3 == 0)
                frame_ready <= 1'b1;
            else
                frame_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int gap;
        int burst;
        int waited;
        in_item_t p;
        rst_n = 1'b0;
        point_valid = 1'b0;
        point = '0;
        long_hold = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, every command, degenerate, flip, orthogonal hint
        send_point(make_point(0, 0, 16384, 0, 0, 0, 0, 0, 0, CMD_NORMAL, 0));
        send_point(make_point(0, 0, -16384, 0, 0, 0, 0, 0, 0, CMD_NORMAL, 1));
        send_point(make_point(16384, 0, 0, 0, 0, 0, 0, 0, 0, CMD_NORMAL, 0));
        send_point(make_point(0, -16384, 0, 0, 0, 0, 0, 0, 0, CMD_NORMAL, 1));
        send_point(make_point(0, 0, 16384, 16384, 0, 0, 0, 16384, 0, CMD_TANGENT, 0));
        send_point(make_point(0, 0, 16384, 16384, 0, 0, 0, -16384, 0, CMD_HINT, 0));
        send_point(make_point(0, 0, 16384, 16384, 0, 0, 0, -16384, 0, CMD_HINT_ALT, 1));
        send_point(make_point(0, 0, 16384, 16384, 0, 0, 0, 0, 16384, CMD_HINT, 0));
        send_point(make_point(0, 0, 16384, 0, 0, 0, 1, 1, 1, CMD_TANGENT, 0));
        send_point(make_point(0, 0, 16384, 0, 0, 5000, 1, 1, 1, CMD_HINT, 1));
        send_point(make_point(0, 0, 0, 100, 200, 300, 1, 1, 1, CMD_TANGENT, 0));
        send_point(make_point(-32768, -32768, -32768, -32768, -32768, -32768,
                              -32768, -32768, -32768, CMD_HINT, 1));
        send_point(make_point(32767, 32767, 32767, 32767, 32767, 32767,
                              32767, 32767, 32767, CMD_HINT, 1));
        send_point(make_point(-32768, 32767, 0, 32767, -32768, 1, -1, 0, 0,
                              CMD_NORMAL, 1));
        send_point(make_point(9459, 9459, 9459, -32768, 0, 32767, 0, 0, 0,
                              CMD_TANGENT, 1));

        // Random: bursts and gaps, with one long output hold-off
        for (int i = 0; i < 1200; )
        begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst; b++)
            begin
                if (i == 300)
                    long_hold <= 1'b1;
                p = rand_point();
                send_point(p);
                i++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                point_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        point_valid <= 1'b0;
        long_hold <= 1'b0;

        // Drain outstanding frames
        waited = 0;
        while (pending_frames != 0 && waited < 200000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (LATENCY + 20) @(negedge clk);
        if (fail_count == 0 && pending_frames == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
